// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; defining NO_ASSERTIONS compiles them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define BWE_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("bit window packer: assertion failed");

`define BWE_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("bit window packer: forbidden condition seen");

`else

`define BWE_ASSERT(label, clk, rst, prop)
`define BWE_NEVER(label, clk, rst, cond)

`endif

`endif

// ===== rtl/bwe_pkg.sv =====
// ---------------------------------------------------------------------------
// Bit window packer package
// Shared types and constants for the bit window extract packer.
// ---------------------------------------------------------------------------
package bwe_pkg;

   localparam int BYTE_W      = 8;
   localparam int START_W     = 10;
   localparam int LEN_W       = 11;
   localparam int CSR_DATA_W  = 11;
   localparam int CSR_IDX_W   = 2;
   localparam int RSP_DEPTH   = 4;
   localparam int RSP_PTR_W   = 2;
   localparam int RSP_CNT_W   = 3;

   localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hff;

   localparam logic [CSR_IDX_W-1:0] REG_FIELD_START  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FIELD_LENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RECORD_BITS  = 2'd2;

   typedef struct packed {
      logic [START_W-1:0] field_start;
      logic [LEN_W-1:0]   field_length;
      logic [LEN_W-1:0]   record_bits;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0] packed_byte;
      logic              byte_valid;
      logic [LEN_W-1:0]  bits_written;
      logic              range_error;
      logic              last_result;
   } rsp_type;

   // Results caused by one input beat, compacted into res_a then res_b.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    res_a;
      rsp_type    res_b;
   } rsp_set_type;

   typedef struct packed {
      logic [RSP_CNT_W-1:0] count;
      logic                 can_take;
   } fifo_stat_type;

endpackage

// ===== rtl/bwe_channels.sv =====
// ---------------------------------------------------------------------------
// Bit window packer channels
// Valid/ready interfaces for the record byte stream and the packed results.
// ---------------------------------------------------------------------------
interface bwe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, data_byte, last_byte, input ready);
   modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface bwe_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  packed_byte;
   logic        byte_valid;
   logic [10:0] bits_written;
   logic        range_error;
   logic        last_result;

   modport source (output valid, packed_byte, byte_valid, bits_written, range_error,
                   last_result, input ready);
   modport sink   (input valid, packed_byte, byte_valid, bits_written, range_error,
                   last_result, output ready);
endinterface

// ===== rtl/bit_window_extract_packer.sv =====
// ---------------------------------------------------------------------------
// Bit window extract packer
// Cuts a configured bit window out of a byte stream and packs it MSB-first.
// ---------------------------------------------------------------------------
// A record byte is taken every cycle while the four-entry result buffer has
// room for two results; with the result side ready, one beat per cycle runs
// indefinitely. Each beat is handled in the cycle it is taken: the window cut,
// the merge into the pending byte and the result build are one level of
// logic feeding the result buffer, so each result is registered into the
// buffer as its beat is taken. A last beat completing a byte and leaving a
// partial one causes two results, leaving the buffer in turn; the output
// port of one result per cycle bounds the sustained rate. Configuration
// registers must be written only while no record is in flight; unchecked.
`include "assert_macros.svh"

module bit_window_extract_packer #(
   parameter int MAX_RECORD_BITS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [bwe_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bwe_pkg::CSR_DATA_W-1:0]      csr_wdata,
   bwe_req_if.sink                             req_bus,
   bwe_rsp_if.source                           rsp_bus
);

   bwe_pkg::cfg_type       cfg_ff;
   bwe_pkg::rsp_set_type   rsp_set;
   bwe_pkg::rsp_type       head;
   bwe_pkg::fifo_stat_type stat;
   logic                   fire, pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            bwe_pkg::REG_FIELD_START: begin
               cfg_ff.field_start <= csr_wdata[bwe_pkg::START_W-1:0];
            end
            bwe_pkg::REG_FIELD_LENGTH: begin
               cfg_ff.field_length <= csr_wdata;
            end
            bwe_pkg::REG_RECORD_BITS: begin
               cfg_ff.record_bits <= csr_wdata;
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   assign req_bus.ready = stat.can_take;
   assign fire          = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid = stat.count != '0;
   assign pop           = rsp_bus.valid && rsp_bus.ready;

   assign rsp_bus.packed_byte  = head.packed_byte;
   assign rsp_bus.byte_valid   = head.byte_valid;
   assign rsp_bus.bits_written = head.bits_written;
   assign rsp_bus.range_error  = head.range_error;
   assign rsp_bus.last_result  = head.last_result;

   bwe_core #(
      .MAX_RECORD_BITS (MAX_RECORD_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .beat_fire (fire),
      .data_byte (req_bus.data_byte),
      .last_byte (req_bus.last_byte),
      .rsp_set   (rsp_set)
   );

   bwe_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .push_set (rsp_set),
      .pop      (pop),
      .head     (head),
      .stat     (stat)
   );

   `BWE_NEVER(a_fifo_overflow, clock, reset, stat.count > 3'(bwe_pkg::RSP_DEPTH))
   `BWE_ASSERT(a_count_track, clock, reset, 1'b1 |=> stat.count == $past(stat.count) + 3'($past(rsp_set.count)) - 3'($past(pop)))
   `BWE_ASSERT(a_error_is_final, clock, reset, (rsp_bus.valid && rsp_bus.range_error) |-> (rsp_bus.last_result && !rsp_bus.byte_valid))
   `BWE_NEVER(a_push_when_full, clock, reset, !fire && rsp_set.count != 2'd0)

endmodule

// ===== rtl/bwe_core.sv =====
// ---------------------------------------------------------------------------
// Bit window packer core
// Per-beat window cut, shift-and-merge into the pending byte, result build.
// ---------------------------------------------------------------------------
module bwe_core #(
   parameter int MAX_RECORD_BITS = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  bwe_pkg::cfg_type                   cfg,
   input  logic                               beat_fire,
   input  logic [bwe_pkg::BYTE_W-1:0]         data_byte,
   input  logic                               last_byte,
   output bwe_pkg::rsp_set_type               rsp_set
);

   localparam int ByteCap = (MAX_RECORD_BITS + 7) / 8;
   localparam int CntW    = $clog2(ByteCap + 1);
   localparam int PosNeed = $clog2(ByteCap * 8 + 9);
   localparam int PosW    = (PosNeed > 12) ? PosNeed : 12;
   localparam int LenW    = bwe_pkg::LEN_W;
   localparam int ByteW   = bwe_pkg::BYTE_W;

   logic [CntW-1:0]  byte_cnt_ff, byte_cnt_in;
   logic [ByteW-1:0] pend_ff, pend_in;
   logic [2:0]       pcnt_ff, pcnt_in;
   logic [LenW-1:0]  extr_ff, extr_in;

   logic [PosW-1:0]  rec_w, s_w, e_w, b0_w, b8_w, lo_w, hi_w, span_w;
   logic             range_bad, take, full, flush;
   logic [3:0]       n_bits, total;
   logic [2:0]       offset;
   logic [ByteW-1:0] shifted, aligned;
   logic [2*ByteW-1:0] acc;
   bwe_pkg::rsp_type data_rsp, tail_rsp, err_rsp;

   always_comb begin
      if (PosW'(cfg.record_bits) > PosW'(MAX_RECORD_BITS)) begin
         rec_w = PosW'(MAX_RECORD_BITS);
      end else begin
         rec_w = PosW'(cfg.record_bits);
      end
      s_w       = PosW'(cfg.field_start);
      e_w       = PosW'(cfg.field_start) + PosW'(cfg.field_length);
      b0_w      = PosW'(byte_cnt_ff) << 3;
      b8_w      = b0_w + PosW'(ByteW);
      range_bad = e_w > rec_w;
      lo_w      = (s_w > b0_w) ? s_w : b0_w;
      hi_w      = (e_w < b8_w) ? e_w : b8_w;
      take      = !range_bad && (lo_w < hi_w);
      span_w    = hi_w - lo_w;
      n_bits    = take ? span_w[3:0] : 4'd0;
      offset    = 3'(lo_w - b0_w);

      // Keep the window bits of this byte MSB-aligned, then slide them
      // behind the bits already pending.
      shifted = data_byte << offset;
      aligned = shifted & ~(bwe_pkg::BYTE_MASK >> n_bits);
      acc     = {pend_ff, {ByteW{1'b0}}} | ({aligned, {ByteW{1'b0}}} >> pcnt_ff);
      total   = {1'b0, pcnt_ff} + n_bits;
      full    = total[3];
      extr_in = extr_ff + LenW'(n_bits);
      pcnt_in = total[2:0];
      pend_in = full ? acc[ByteW-1:0] : acc[2*ByteW-1:ByteW];
      flush   = last_byte && (pcnt_in != 3'd0);

      data_rsp.packed_byte  = acc[2*ByteW-1:ByteW];
      data_rsp.byte_valid   = 1'b1;
      data_rsp.bits_written = (last_byte && !flush) ? extr_in : '0;
      data_rsp.range_error  = 1'b0;
      data_rsp.last_result  = last_byte && !flush;

      tail_rsp.packed_byte  = flush ? pend_in : '0;
      tail_rsp.byte_valid   = flush;
      tail_rsp.bits_written = extr_in;
      tail_rsp.range_error  = 1'b0;
      tail_rsp.last_result  = 1'b1;

      err_rsp.packed_byte  = '0;
      err_rsp.byte_valid   = 1'b0;
      err_rsp.bits_written = '0;
      err_rsp.range_error  = 1'b1;
      err_rsp.last_result  = 1'b1;

      rsp_set.res_a = data_rsp;
      rsp_set.res_b = tail_rsp;
      rsp_set.count = 2'd0;
      if (range_bad) begin
         rsp_set.res_a = err_rsp;
         rsp_set.count = last_byte ? 2'd1 : 2'd0;
      end else if (full) begin
         rsp_set.count = flush ? 2'd2 : 2'd1;
      end else if (last_byte) begin
         rsp_set.res_a = tail_rsp;
         rsp_set.count = 2'd1;
      end
      if (!beat_fire) begin
         rsp_set.count = 2'd0;
      end

      if (byte_cnt_ff < CntW'(ByteCap)) begin
         byte_cnt_in = byte_cnt_ff + CntW'(1);
      end else begin
         byte_cnt_in = byte_cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_cnt_ff <= '0;
         pend_ff     <= '0;
         pcnt_ff     <= '0;
         extr_ff     <= '0;
      end else if (beat_fire) begin
         if (last_byte) begin
            byte_cnt_ff <= '0;
            pend_ff     <= '0;
            pcnt_ff     <= '0;
            extr_ff     <= '0;
         end else begin
            byte_cnt_ff <= byte_cnt_in;
            if (!range_bad) begin
               pend_ff <= pend_in;
               pcnt_ff <= pcnt_in;
               extr_ff <= extr_in;
            end
         end
      end
   end

endmodule

// ===== rtl/bwe_rsp_fifo.sv =====
// ---------------------------------------------------------------------------
// Bit window packer result buffer
// Four-entry result queue taking up to two results per cycle.
// ---------------------------------------------------------------------------
module bwe_rsp_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  bwe_pkg::rsp_set_type    push_set,
   input  logic                    pop,
   output bwe_pkg::rsp_type        head,
   output bwe_pkg::fifo_stat_type  stat
);

   localparam int PtrW = bwe_pkg::RSP_PTR_W;
   localparam int CntW = bwe_pkg::RSP_CNT_W;

   bwe_pkg::rsp_type slot_ff [bwe_pkg::RSP_DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]  count_ff, count_in;
   logic [PtrW-1:0]  wr_next_ptr;

   always_comb begin
      wr_next_ptr   = wr_ptr_ff + PtrW'(1);
      count_in      = count_ff + CntW'(push_set.count) - CntW'(pop);
      head          = slot_ff[rd_ptr_ff];
      stat.count    = count_ff;
      // Room for the largest set of results one beat can cause.
      stat.can_take = count_ff <= CntW'(bwe_pkg::RSP_DEPTH - 2);
   end

   always_ff @(posedge clock) begin
      if (push_set.count != 2'd0) begin
         slot_ff[wr_ptr_ff] <= push_set.res_a;
      end
      if (push_set.count == 2'd2) begin
         slot_ff[wr_next_ptr] <= push_set.res_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + PtrW'(push_set.count);
         rd_ptr_ff <= rd_ptr_ff + PtrW'(pop);
         count_ff  <= count_in;
      end
   end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Bit window extract packer testbench
// Streams records of random bytes through the packer under several window
// settings and checks every packed result against a cycle-free prediction.
// ---------------------------------------------------------------------------
module tb_top;

   localparam int MAX_BITS    = 1024;
   localparam int BYTE_CAP    = (MAX_BITS + 7) / 8;
   localparam int TARGET_BEAT = 800;
   localparam int LONG_HOLD   = 300;
   localparam int LIMIT       = 500000;

   typedef enum int {RX_STREAM, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_type;

   // Predicts the packed bytes of each record and checks them in order.
   class packed_byte_checker;
      int unsigned      field_start;
      int unsigned      field_length;
      int unsigned      record_bits;
      int unsigned      byte_index;
      int unsigned      held_bits;
      int unsigned      held_count;
      int unsigned      window_bits_taken;
      int unsigned      mismatches;
      bwe_pkg::rsp_type due_bytes[$];

      function void set_register(logic [bwe_pkg::CSR_IDX_W-1:0]  idx,
                                 logic [bwe_pkg::CSR_DATA_W-1:0] value);
         case (idx)
            bwe_pkg::REG_FIELD_START:  field_start  = value[bwe_pkg::START_W-1:0];
            bwe_pkg::REG_FIELD_LENGTH: field_length = value;
            bwe_pkg::REG_RECORD_BITS:  record_bits  = value;
            default: ;
         endcase
      endfunction

      function void clear_record();
         byte_index        = 0;
         held_bits         = 0;
         held_count        = 0;
         window_bits_taken = 0;
      endfunction

      function void take_record_byte(logic [7:0] data, logic last);
         int unsigned      rec, win_end, b0, lo, hi, n, v, acc, total, dv, produced;
         bwe_pkg::rsp_type r;
         rec      = (record_bits > MAX_BITS) ? MAX_BITS : record_bits;
         win_end  = field_start + field_length;
         produced = 0;
         dv       = data;
         if (win_end > rec) begin
            // The window does not fit: nothing until the last beat flags it.
            if (last) begin
               r = '0;
               r.range_error = 1'b1;
               r.last_result = 1'b1;
               due_bytes.push_back(r);
               clear_record();
            end else if (byte_index < BYTE_CAP) begin
               byte_index++;
            end
            return;
         end
         b0 = byte_index * 8;
         lo = (field_start > b0) ? field_start : b0;
         hi = (win_end < b0 + 8) ? win_end : b0 + 8;
         if (lo < hi) begin
            n     = hi - lo;
            v     = ((dv << (lo - b0)) & 'hff) >> (8 - n);
            acc   = (held_bits << 8) | (v << (16 - held_count - n));
            total = held_count + n;
            window_bits_taken += n;
            if (total >= 8) begin
               r = '0;
               r.packed_byte = 8'(acc >> 8);
               r.byte_valid  = 1'b1;
               due_bytes.push_back(r);
               produced++;
               held_bits  = acc & 'hff;
               held_count = total - 8;
            end else begin
               held_bits  = (acc >> 8) & 'hff;
               held_count = total;
            end
         end
         if (byte_index < BYTE_CAP) byte_index++;
         if (!last) return;
         if (held_count > 0) begin
            r = '0;
            r.packed_byte  = 8'(held_bits);
            r.byte_valid   = 1'b1;
            r.bits_written = 11'(window_bits_taken);
            r.last_result  = 1'b1;
            due_bytes.push_back(r);
         end else if (produced > 0) begin
            due_bytes[$].bits_written = 11'(window_bits_taken);
            due_bytes[$].last_result  = 1'b1;
         end else begin
            r = '0;
            r.bits_written = 11'(window_bits_taken);
            r.last_result  = 1'b1;
            due_bytes.push_back(r);
         end
         clear_record();
      endfunction

      function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
         if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatches++;
         end
      endfunction

      function void check_packed_result(bwe_pkg::rsp_type got);
         bwe_pkg::rsp_type want;
         if (due_bytes.size() == 0) begin
            $error("result beat with nothing predicted: byte %0h last %0b",
                   got.packed_byte, got.last_result);
            mismatches++;
            return;
         end
         want = due_bytes.pop_front();
         compare_field("packed_byte",  want.packed_byte,  got.packed_byte);
         compare_field("byte_valid",   want.byte_valid,   got.byte_valid);
         compare_field("bits_written", want.bits_written, got.bits_written);
         compare_field("range_error",  want.range_error,  got.range_error);
         compare_field("last_result",  want.last_result,  got.last_result);
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           csr_we;
   logic [bwe_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [bwe_pkg::CSR_DATA_W-1:0] csr_wdata;

   bwe_req_if req_if ();
   bwe_rsp_if rsp_if ();

   packed_byte_checker sb = new();

   int unsigned cycle_count = 0;
   int unsigned beats_sent  = 0;
   int unsigned burst_left  = 0;
   bit          steady_sender = 1'b0;
   bit          hold_request  = 1'b0;

   // Receiver-side state, written only by the receiver process.
   bit          hold_seen = 1'b0;
   int unsigned hold_left = 0;
   int unsigned mode_left = 0;
   rx_mode_type stall_mode = RX_STREAM;

   bit_window_extract_packer u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_bus   (req_if),
      .rsp_bus   (rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Result side: check accepted beats, then pick next cycle's ready.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            sb.check_packed_result('{packed_byte:  rsp_if.packed_byte,
                                     byte_valid:   rsp_if.byte_valid,
                                     bits_written: rsp_if.bits_written,
                                     range_error:  rsp_if.range_error,
                                     last_result:  rsp_if.last_result});
         end
         if (hold_seen != hold_request) begin
            hold_seen = hold_request;
            hold_left = LONG_HOLD;
         end
         if (mode_left == 0) begin
            stall_mode = rx_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 300);
         end else begin
            mode_left--;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            case (stall_mode)
               RX_STREAM: rsp_if.ready <= 1'b1;
               RX_HALF:   rsp_if.ready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_if.ready <= ($urandom_range(0, 3) == 0);
               default:   rsp_if.ready <= ($urandom_range(0, 4) != 0);
            endcase
         end
      end
   end

   // Offers one record byte and returns at the edge that takes it.
   task automatic send_byte(logic [7:0] data, logic last);
      req_if.valid     <= 1'b1;
      req_if.data_byte <= data;
      req_if.last_byte <= last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.take_record_byte(data, last);
      beats_sent++;
   endtask

   // Bursts of back-to-back beats separated by random gaps, unless steady_sender is set.
   task automatic pace_sender();
      int unsigned gap;
      if (!steady_sender && burst_left == 0) begin
         gap = $urandom_range(1, 8);
         req_if.valid     <= 1'b0;
         req_if.data_byte <= 8'($urandom_range(0, 255));
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 16);
      end
      if (burst_left != 0) burst_left--;
   endtask

   task automatic send_record(logic [7:0] bytes_q[$]);
      for (int i = 0; i < bytes_q.size(); i++) begin
         pace_sender();
         send_byte(bytes_q[i], i == bytes_q.size() - 1);
      end
   endtask

   task automatic send_random_record(int unsigned nbytes);
      logic [7:0] bytes_q[$];
      for (int i = 0; i < nbytes; i++) bytes_q.push_back(8'($urandom_range(0, 255)));
      send_record(bytes_q);
   endtask

   // Lets the block drain: every predicted beat back, then a few spare cycles.
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.due_bytes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_settings(int unsigned start, int unsigned len, int unsigned rec);
      logic [bwe_pkg::CSR_IDX_W-1:0]  idx [3];
      logic [bwe_pkg::CSR_DATA_W-1:0] val [3];
      idx = '{bwe_pkg::REG_FIELD_START, bwe_pkg::REG_FIELD_LENGTH,
              bwe_pkg::REG_RECORD_BITS};
      val = '{bwe_pkg::CSR_DATA_W'(start), bwe_pkg::CSR_DATA_W'(len),
              bwe_pkg::CSR_DATA_W'(rec)};
      wait_idle();
      for (int i = 0; i < 3; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
         sb.set_register(idx[i], val[i]);
      end
      csr_we <= 1'b0;
   endtask

   initial begin
      logic [7:0]  rec_q[$];
      int unsigned phase, kind, start, len, rec, nbytes, records, lo_len;
      reset            <= 1'b1;
      csr_we           <= 1'b0;
      csr_index        <= bwe_pkg::REG_FIELD_START;
      csr_wdata        <= '0;
      req_if.valid     <= 1'b0;
      req_if.data_byte <= '0;
      req_if.last_byte <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed records: aligned full byte, window across bytes, byte
      // completed on the last beat, empty window, window past the record,
      // two results from one last beat, oversized record length, short record.
      apply_settings(0, 8, 8);
      rec_q = '{8'hff};
      send_record(rec_q);
      apply_settings(3, 10, 24);
      rec_q = '{8'ha5, 8'h3c, 8'h00};
      send_record(rec_q);
      apply_settings(4, 8, 16);
      rec_q = '{8'h0f, 8'hf0};
      send_record(rec_q);
      apply_settings(0, 0, 0);
      rec_q = '{8'h00};
      send_record(rec_q);
      apply_settings(1023, 1024, 1024);
      rec_q = '{8'h55, 8'haa};
      send_record(rec_q);
      apply_settings(4, 12, 16);
      rec_q = '{8'h5a, 8'hc3};
      send_record(rec_q);
      apply_settings(0, 12, 2047);
      rec_q = '{8'hff, 8'h81};
      send_record(rec_q);
      apply_settings(0, 24, 24);
      rec_q = '{8'h96, 8'h69};
      send_record(rec_q);

      phase = 0;
      while (beats_sent < TARGET_BEAT) begin
         if (phase % 8 == 0) begin
            // Full-size records; the receiver holds off so the block backs up.
            kind = (phase == 0) ? 0 : $urandom_range(0, 3);
            case (kind)
               0: begin start = 0; len = 1024; rec = 1024; end
               1: begin start = 1023; len = 1; rec = 2047; end
               2: begin
                  start = $urandom_range(0, 1023);
                  len   = 1024 - start;
                  rec   = 1024;
               end
               default: begin
                  start = $urandom_range(0, 1023);
                  len   = $urandom_range(0, 1024 - start);
                  rec   = $urandom_range(1024, 2047);
               end
            endcase
            apply_settings(start, len, rec);
            steady_sender = 1'b1;
            hold_request  = ~hold_request;
            send_random_record(BYTE_CAP + $urandom_range(0, 3));
         end else begin
            kind = $urandom_range(0, 99);
            if (kind < 15) begin
               rec    = $urandom_range(0, 80);
               start  = $urandom_range(0, 1023);
               lo_len = (rec + 1 > start) ? rec + 1 - start : 0;
               len    = $urandom_range(lo_len, 1024);
            end else if (kind < 25) begin
               rec   = $urandom_range(1025, 2047);
               start = $urandom_range(0, 60);
               len   = $urandom_range(0, 60);
            end else begin
               rec   = $urandom_range(0, 80);
               start = $urandom_range(0, rec);
               len   = $urandom_range(0, rec - start);
            end
            apply_settings(start, len, rec);
            steady_sender = ($urandom_range(0, 4) == 0);
            records = $urandom_range(1, 4);
            repeat (records) begin
               if (kind < 15) begin
                  nbytes = $urandom_range(1, 10);
               end else if (kind < 25) begin
                  nbytes = (start + len + 7) / 8 + $urandom_range(0, 2);
               end else if ($urandom_range(0, 3) == 0) begin
                  // Records cut short or running past their stated length.
                  nbytes = $urandom_range(1, (rec + 7) / 8 + 2);
               end else begin
                  nbytes = (rec + 7) / 8;
               end
               if (nbytes == 0) nbytes = 1;
               send_random_record(nbytes);
            end
         end
         phase++;
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.due_bytes.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
